// ----- rtl/bole_pkg.sv -----
`default_nettype none
package bole_pkg;
  localparam int Capacity = 32;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  typedef enum logic [3:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_INS_AT    = 4'd2,
    OP_DEL_FRONT = 4'd3,
    OP_DEL_BACK  = 4'd4,
    OP_DEL_AT    = 4'd5,
    OP_LIST_FWD  = 4'd6,
    OP_LIST_REV  = 4'd7,
    OP_QUERY     = 4'd8,
    OP_REVERSE   = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LIST = 2'd1,
    S_OUT  = 2'd2
  } state_t;

  typedef enum logic [2:0] {
    DP_NONE   = 3'd0,
    DP_INSERT = 3'd1,
    DP_DELETE = 3'd2,
    DP_REVERSE = 3'd3,
    DP_STATUS = 3'd4,
    DP_LIST   = 3'd5
  } dpop_t;

  // controller -> datapath
  typedef struct packed {
    dpop_t           op;
    logic [IdxW-1:0] idx;      // insert/delete slot
    status_t         status;
    logic            list_start;
    logic            list_rev;
    logic            list_step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            list_last;
  } stat_t;
endpackage
`default_nettype wire

// ----- rtl/bounded_ordered_list_engine.sv -----
// channel | ports                                        | direction
// input   | in_valid in_stall in_operation in_value in_position | into block
// output  | out_valid out_stall out_result_value out_status out_last
//         |   out_empty_flag out_element_count              | out of block
// An edit or query takes a word; an edit also updates the cell array at the edge that
// accepts it, and the result is held in the output register until it is taken.
// A listing gives one word per cycle from the cell array while out_stall is low, count words in all.
// The input stalls while a result is pending; out_stall holds all results.
// Reset (rst_n low, synchronous) empties the list; cell contents are not cleared.
`default_nettype none
module bounded_ordered_list_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         in_operation,
  input  wire logic signed [31:0] in_value,
  input  wire logic [5:0]         in_position,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_result_value,
  output logic [1:0]              out_status,
  output logic                    out_last,
  output logic                    out_empty_flag,
  output logic [5:0]              out_element_count
);
  bole_pkg::cmd_t  cmd;
  bole_pkg::stat_t stat;

  // sequencer: decodes the word, checks ranges, paces listings
  bole_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation, .in_position,
    .out_valid, .out_stall, .cmd, .stat
  );

  // cell array with shift/mirror network and result register
  bole_dp u_dp (
    .clk, .rst_n, .cmd, .in_value(in_value), .stat,
    .out_result_value, .out_status, .out_last, .out_empty_flag, .out_element_count
  );
endmodule
`default_nettype wire

// ----- rtl/bole_ctrl.sv -----
`default_nettype none
module bole_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [3:0]           in_operation,
  input  wire logic [5:0]           in_position,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output bole_pkg::cmd_t            cmd,
  input  wire bole_pkg::stat_t      stat
);
  bole_pkg::state_t state_r, state_nxt;
  logic acc, fire;
  logic [bole_pkg::CntW-1:0] cnt;
  logic [6:0] pos;

  assign cnt  = stat.count;
  assign pos  = {1'b0, in_position};
  assign fire = out_valid && !out_stall;
  assign acc  = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bole_pkg::S_IDLE: begin
        if (in_valid) begin
          if ((in_operation == bole_pkg::OP_LIST_FWD ||
               in_operation == bole_pkg::OP_LIST_REV) && cnt != '0)
            state_nxt = bole_pkg::S_LIST;
          else
            state_nxt = bole_pkg::S_OUT;
        end
      end
      bole_pkg::S_LIST: if (fire && stat.list_last) state_nxt = bole_pkg::S_IDLE;
      bole_pkg::S_OUT:  if (fire) state_nxt = bole_pkg::S_IDLE;
      default: state_nxt = bole_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bole_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // outputs
  always_comb begin
    logic [6:0] c7;
    c7 = 7'(cnt);
    in_stall  = (state_r != bole_pkg::S_IDLE);
    out_valid = (state_r != bole_pkg::S_IDLE);
    cmd = '0;
    cmd.list_step = (state_r == bole_pkg::S_LIST) && fire;
    if (acc) begin
      cmd.op = bole_pkg::DP_STATUS;
      cmd.status = bole_pkg::ST_OK;
      case (in_operation)
        bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_BACK: begin
          if (c7 >= 7'(bole_pkg::Capacity)) cmd.status = bole_pkg::ST_FULL;
          else begin
            cmd.op  = bole_pkg::DP_INSERT;
            cmd.idx = (in_operation == bole_pkg::OP_INS_FRONT) ? '0
                      : bole_pkg::IdxW'(cnt);
          end
        end
        bole_pkg::OP_INS_AT: begin
          if (pos == 7'd0 || pos > c7 + 7'd1) cmd.status = bole_pkg::ST_BADPOS;
          else if (c7 >= 7'(bole_pkg::Capacity)) cmd.status = bole_pkg::ST_FULL;
          else begin
            cmd.op  = bole_pkg::DP_INSERT;
            cmd.idx = bole_pkg::IdxW'(pos - 7'd1);
          end
        end
        bole_pkg::OP_DEL_FRONT, bole_pkg::OP_DEL_BACK: begin
          if (cnt == '0) cmd.status = bole_pkg::ST_EMPTY;
          else begin
            cmd.op  = bole_pkg::DP_DELETE;
            cmd.idx = (in_operation == bole_pkg::OP_DEL_FRONT) ? '0
                      : bole_pkg::IdxW'(c7 - 7'd1);
          end
        end
        bole_pkg::OP_DEL_AT: begin
          if (pos == 7'd0) cmd.status = bole_pkg::ST_BADPOS;
          else if (cnt == '0) cmd.status = bole_pkg::ST_EMPTY;
          else if (pos > c7) cmd.status = bole_pkg::ST_BADPOS;
          else begin
            cmd.op  = bole_pkg::DP_DELETE;
            cmd.idx = bole_pkg::IdxW'(pos - 7'd1);
          end
        end
        bole_pkg::OP_LIST_FWD, bole_pkg::OP_LIST_REV: begin
          if (cnt == '0) cmd.status = bole_pkg::ST_EMPTY;
          else begin
            cmd.op = bole_pkg::DP_LIST;
            cmd.list_start = 1'b1;
            cmd.list_rev = (in_operation == bole_pkg::OP_LIST_REV);
          end
        end
        bole_pkg::OP_REVERSE: cmd.op = bole_pkg::DP_REVERSE;
        default: cmd.op = bole_pkg::DP_STATUS;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/bole_dp.sv -----
`default_nettype none
module bole_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bole_pkg::cmd_t      cmd,
  input  wire logic [31:0]         in_value,
  output bole_pkg::stat_t          stat,
  output logic signed [31:0]       out_result_value,
  output logic [1:0]               out_status,
  output logic                     out_last,
  output logic                     out_empty_flag,
  output logic [5:0]               out_element_count
);
  localparam int N = bole_pkg::Capacity;
  localparam int IW = bole_pkg::IdxW;
  localparam int CW = bole_pkg::CntW;

  logic [31:0] cell_r [N];
  logic [31:0] cell_nxt [N];
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;     // listing pointer
  logic [CW-1:0] left_r, left_nxt;   // elements still to list
  logic          rev_r;
  logic [31:0]   res_r, res_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          last_r, last_nxt;
  logic [IW:0]   top;

  assign top = (IW + 1)'(count_r) - (IW + 1)'(1);

  always_comb begin
    for (int i = 0; i < N; i++) cell_nxt[i] = cell_r[i];
    count_nxt = count_r;
    ptr_nxt = ptr_r;
    left_nxt = left_r;
    res_nxt = res_r;
    st_nxt = st_r;
    last_nxt = last_r;
    case (cmd.op)
      bole_pkg::DP_INSERT: begin
        // each cell picks its left neighbor, new word, or itself
        for (int i = 0; i < N; i++) begin
          if (IW'(i) == cmd.idx) cell_nxt[i] = in_value;
          else if (IW'(i) > cmd.idx && i > 0) cell_nxt[i] = cell_r[(i + N - 1) % N];
        end
        count_nxt = count_r + CW'(1);
        res_nxt = '0; st_nxt = bole_pkg::ST_OK; last_nxt = 1'b1;
      end
      bole_pkg::DP_DELETE: begin
        for (int i = 0; i < N - 1; i++)
          if (IW'(i) >= cmd.idx) cell_nxt[i] = cell_r[i + 1];
        count_nxt = count_r - CW'(1);
        res_nxt = cell_r[cmd.idx]; st_nxt = bole_pkg::ST_OK; last_nxt = 1'b1;
      end
      bole_pkg::DP_REVERSE: begin
        // mirror cell i with cell count-1-i for cells below count
        for (int i = 0; i < N; i++)
          if ((IW + 1)'(i) <= top && count_r > CW'(1))
            cell_nxt[i] = cell_r[IW'(top - (IW + 1)'(i))];
        res_nxt = '0; st_nxt = bole_pkg::ST_OK; last_nxt = 1'b1;
      end
      bole_pkg::DP_STATUS: begin
        res_nxt = '0; st_nxt = cmd.status; last_nxt = 1'b1;
      end
      bole_pkg::DP_LIST: begin
        ptr_nxt = cmd.list_rev ? IW'(top) : '0;
        left_nxt = count_r;
        res_nxt = cmd.list_rev ? cell_r[IW'(top)] : cell_r[0];
        st_nxt = bole_pkg::ST_OK;
        last_nxt = (count_r == CW'(1));
      end
      default: begin
        if (cmd.list_step) begin
          ptr_nxt = rev_r ? ptr_r - IW'(1) : ptr_r + IW'(1);
          left_nxt = left_r - CW'(1);
          res_nxt = cell_r[ptr_nxt];
          last_nxt = (left_r == CW'(2));
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else        count_r <= count_nxt;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) cell_r[i] <= cell_nxt[i];
    ptr_r <= ptr_nxt;
    left_r <= left_nxt;
    res_r <= res_nxt;
    st_r <= st_nxt;
    last_r <= last_nxt;
    if (cmd.list_start) rev_r <= cmd.list_rev;
  end

  assign stat.count = count_r;
  assign stat.list_last = last_r;
  assign out_result_value = res_r;
  assign out_status = st_r;
  assign out_last = last_r;
  assign out_empty_flag = (count_r == '0);
  assign out_element_count = 6'(count_r);
endmodule
`default_nettype wire

// ----- bench/bounded_ordered_list_engine_tb.sv -----
`default_nettype none
module bounded_ordered_list_engine_tb;

  localparam int Cap = bole_pkg::Capacity;
  localparam int CycleLimit = 400000;
  // codes outside the defined operation set
  localparam logic [3:0] OpUndefLo = 4'd10;
  localparam logic [3:0] OpUndefHi = 4'd15;

  // one pending word for the input side
  typedef struct {
    logic [3:0]         op;
    logic signed [31:0] val;
    logic [5:0]         pos;
  } cmd_word_t;

  // one expected result word
  typedef struct {
    logic signed [31:0] val;
    logic [1:0]         status;
    logic               last;
    logic               empty;
    logic [5:0]         count;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_operation = '0;
  logic signed [31:0] in_value = '0;
  logic [5:0] in_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_result_value;
  logic [1:0] out_status;
  logic out_last;
  logic out_empty_flag;
  logic [5:0] out_element_count;

  bounded_ordered_list_engine uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_value(in_value), .in_position(in_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_value(out_result_value), .out_status(out_status),
    .out_last(out_last), .out_empty_flag(out_empty_flag),
    .out_element_count(out_element_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow list: cells[0] is the front
  logic signed [31:0] cells [Cap];
  int list_len = 0;

  cmd_word_t    cmd_queue[$];
  result_word_t expected_words[$];

  int errors = 0;
  int cycles = 0;
  int accepted = 0;
  int total_cmds = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 1'b0;
  bit hold_send = 1'b0;

  // stall as seen at the last rising edge
  logic in_stall_q = 1'b0;

  function automatic result_word_t make_word(logic signed [31:0] v, bole_pkg::status_t st,
                                             logic lst);
    result_word_t w;
    w.val = v;
    w.status = st;
    w.last = lst;
    w.empty = (list_len == 0);
    w.count = list_len[5:0];
    return w;
  endfunction

  // applies one command to the shadow list and queues what the block must emit
  task automatic apply_list_op(cmd_word_t c);
    int slot;
    logic signed [31:0] removed;
    logic signed [31:0] tmp;
    int lo;
    int hi;
    slot = -1;
    case (c.op)
      bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_BACK, bole_pkg::OP_INS_AT: begin
        if (c.op == bole_pkg::OP_INS_AT && (c.pos < 1 || c.pos > list_len + 1)) begin
          expected_words.push_back(make_word(0, bole_pkg::ST_BADPOS, 1'b1));
        end else if (list_len >= Cap) begin
          expected_words.push_back(make_word(0, bole_pkg::ST_FULL, 1'b1));
        end else begin
          slot = (c.op == bole_pkg::OP_INS_FRONT) ? 0 :
                 (c.op == bole_pkg::OP_INS_BACK) ? list_len : c.pos - 1;
          for (int i = list_len; i > slot; i--) cells[i] = cells[i-1];
          cells[slot] = c.val;
          list_len++;
          expected_words.push_back(make_word(0, bole_pkg::ST_OK, 1'b1));
        end
      end
      bole_pkg::OP_DEL_FRONT, bole_pkg::OP_DEL_BACK, bole_pkg::OP_DEL_AT: begin
        if (c.op == bole_pkg::OP_DEL_AT && c.pos < 1) begin
          expected_words.push_back(make_word(0, bole_pkg::ST_BADPOS, 1'b1));
        end else if (list_len == 0) begin
          expected_words.push_back(make_word(0, bole_pkg::ST_EMPTY, 1'b1));
        end else if (c.op == bole_pkg::OP_DEL_AT && c.pos > list_len) begin
          expected_words.push_back(make_word(0, bole_pkg::ST_BADPOS, 1'b1));
        end else begin
          slot = (c.op == bole_pkg::OP_DEL_FRONT) ? 0 :
                 (c.op == bole_pkg::OP_DEL_BACK) ? list_len - 1 : c.pos - 1;
          removed = cells[slot];
          for (int i = slot; i + 1 < list_len; i++) cells[i] = cells[i+1];
          list_len--;
          expected_words.push_back(make_word(removed, bole_pkg::ST_OK, 1'b1));
        end
      end
      bole_pkg::OP_LIST_FWD, bole_pkg::OP_LIST_REV: begin
        if (list_len == 0) begin
          expected_words.push_back(make_word(0, bole_pkg::ST_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < list_len; i++) begin
            slot = (c.op == bole_pkg::OP_LIST_FWD) ? i : list_len - 1 - i;
            expected_words.push_back(make_word(cells[slot], bole_pkg::ST_OK,
                                               i + 1 == list_len));
          end
        end
      end
      bole_pkg::OP_REVERSE: begin
        lo = 0;
        hi = list_len - 1;
        while (lo < hi) begin
          tmp = cells[lo];
          cells[lo] = cells[hi];
          cells[hi] = tmp;
          lo++;
          hi--;
        end
        expected_words.push_back(make_word(0, bole_pkg::ST_OK, 1'b1));
      end
      default: expected_words.push_back(make_word(0, bole_pkg::ST_OK, 1'b1));
    endcase
  endtask

  function automatic cmd_word_t mk(logic [3:0] op, logic signed [31:0] v, logic [5:0] p);
    cmd_word_t c;
    c.op = op;
    c.val = v;
    c.pos = p;
    return c;
  endfunction

  // random command, weighted toward edits so the list fills and drains
  function automatic cmd_word_t rand_cmd(int fill_bias);
    cmd_word_t c;
    int r;
    r = $urandom_range(99);
    c.val = $urandom;
    if ($urandom_range(9) == 0) c.val = ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
    c.pos = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(35));
    if (r < fill_bias)
      c.op = 4'($urandom_range(bole_pkg::OP_INS_AT, bole_pkg::OP_INS_FRONT));
    else if (r < 80)
      c.op = 4'($urandom_range(bole_pkg::OP_DEL_AT, bole_pkg::OP_DEL_FRONT));
    else if (r < 88)
      c.op = 4'($urandom_range(bole_pkg::OP_LIST_REV, bole_pkg::OP_LIST_FWD));
    else if (r < 97)
      c.op = 4'($urandom_range(bole_pkg::OP_REVERSE, bole_pkg::OP_QUERY));
    else
      c.op = 4'($urandom_range(OpUndefHi, OpUndefLo));
    return c;
  endfunction

  // driver: presents the queue head; advances only on acceptance
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_q) begin
        void'(cmd_queue.pop_front());
      end
      if (cmd_queue.size() > 0 && !hold_send &&
          !(in_valid && !in_stall_q && cmd_queue.size() == 0) &&
          (in_valid && in_stall_q || $urandom_range(99) >= send_idle_pct)) begin
        in_valid <= 1'b1;
        in_operation <= cmd_queue[0].op;
        in_value <= cmd_queue[0].val;
        in_position <= cmd_queue[0].pos;
      end else begin
        in_valid <= 1'b0;
      end
      out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) in_stall_q <= in_stall;

  // input side acceptance: predict at the edge the word is taken
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && !in_stall) begin
      apply_list_op(mk(in_operation, in_value, in_position));
      accepted <= accepted + 1;
    end
  end

  // monitor: compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    result_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word val=%0d st=%0d last=%0b empty=%0b cnt=%0d", $time,
                 out_result_value, out_status, out_last, out_empty_flag, out_element_count);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_result_value !== e.val || out_status !== e.status || out_last !== e.last ||
            out_empty_flag !== e.empty || out_element_count !== e.count) begin
          $display("%0t: mismatch exp val=%0d st=%0d last=%0b empty=%0b cnt=%0d", $time,
                   e.val, e.status, e.last, e.empty, e.count);
          $display("%0t:          got val=%0d st=%0d last=%0b empty=%0b cnt=%0d", $time,
                   out_result_value, out_status, out_last, out_empty_flag, out_element_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push(cmd_word_t c);
    cmd_queue.push_back(c);
    total_cmds++;
  endtask

  task automatic wait_drained();
    while (accepted < total_cmds || expected_words.size() > 0) @(posedge clk);
  endtask

  task automatic random_phase(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      // bursts weighted to fill the store alternate with mixed traffic
      push(rand_cmd((i / 40) % 2 == 0 ? 70 : 35));
      if (cmd_queue.size() > 8) @(posedge clk);
      while (cmd_queue.size() > 8) @(posedge clk);
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: empty-list cases first
    push(mk(bole_pkg::OP_LIST_FWD, 0, 0));
    push(mk(bole_pkg::OP_LIST_REV, 0, 0));
    push(mk(bole_pkg::OP_DEL_FRONT, 0, 0));
    push(mk(bole_pkg::OP_DEL_BACK, 0, 0));
    push(mk(bole_pkg::OP_DEL_AT, 0, 0));
    push(mk(bole_pkg::OP_DEL_AT, 0, 1));
    push(mk(bole_pkg::OP_INS_AT, 5, 2));
    push(mk(bole_pkg::OP_QUERY, 0, 0));
    push(mk(bole_pkg::OP_REVERSE, 0, 0));
    push(mk(bole_pkg::OP_INS_AT, 32'sh7fffffff, 1));
    push(mk(bole_pkg::OP_REVERSE, 0, 0));
    push(mk(bole_pkg::OP_INS_FRONT, 32'sh80000000, 63));
    push(mk(bole_pkg::OP_INS_BACK, -1, 0));
    push(mk(bole_pkg::OP_INS_AT, 7, 0));
    push(mk(bole_pkg::OP_INS_AT, 9, 4));
    push(mk(bole_pkg::OP_INS_AT, 8, 5));
    push(mk(bole_pkg::OP_LIST_FWD, 0, 0));
    push(mk(bole_pkg::OP_REVERSE, 0, 0));
    push(mk(bole_pkg::OP_LIST_REV, 0, 0));
    push(mk(bole_pkg::OP_DEL_AT, 0, 6));
    push(mk(bole_pkg::OP_DEL_AT, 0, 2));
    push(mk(OpUndefLo, 1, 1));
    push(mk(OpUndefHi, -1, 63));
    push(mk(bole_pkg::OP_QUERY, 0, 0));
    wait_drained();

    // fill to full, then three more inserts (front, at 1, at 34), then list full store
    for (int i = 0; i < Cap; i++) push(mk(bole_pkg::OP_INS_BACK, $urandom, 0));
    push(mk(bole_pkg::OP_INS_FRONT, 1, 0));
    push(mk(bole_pkg::OP_INS_AT, 1, 1));
    push(mk(bole_pkg::OP_INS_AT, 1, 34));
    push(mk(bole_pkg::OP_LIST_FWD, 0, 0));

    // long receiver hold while words keep coming: input must back up
    hold_recv = 1'b1;
    repeat (300) @(posedge clk);
    hold_recv = 1'b0;
    wait_drained();

    // sender pauses until all results are in
    hold_send = 1'b1;
    wait_drained();
    hold_send = 1'b0;

    random_phase(130, 19, 75);
    random_phase(130, 75, 19);
    random_phase(150, 0, 0);

    repeat (50) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- bounded_ordered_list_engine.f -----
rtl/bole_pkg.sv
rtl/bole_ctrl.sv
rtl/bole_dp.sv
rtl/bounded_ordered_list_engine.sv
bench/bounded_ordered_list_engine_tb.sv
